/* src/restoring_divider_64_assert.svh */
`ifndef RESTORING_DIVIDER_64_ASSERT_SVH
`define RESTORING_DIVIDER_64_ASSERT_SVH

// Check on every clock edge outside reset.
`define RD64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define RD64_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* src/rd64_pkg.sv */
package rd64_pkg;

  // Width of the data fields on the ports
  localparam int unsigned DATA_W = 64;
  localparam int unsigned OP_W   = 2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SDIV = 2'd0,
    OP_SREM = 2'd1,
    OP_UDIV = 2'd2,
    OP_UREM = 2'd3
  } op_e;

  // Per-transaction control that rides along the cell chain
  typedef struct packed {
    logic is_rem;  // deliver remainder instead of quotient
    logic neg_q;   // negate the quotient magnitude
    logic neg_r;   // negate the remainder magnitude
    logic dz;      // divisor is zero
  } ctrl_t;

endpackage

/* src/rd64_prep.sv */
module rd64_prep
  import rd64_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  input  op_e              op_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] num_o,
  output logic [WIDTH-1:0] den_o,
  output ctrl_t            ctrl_o
);

  logic             is_signed;
  logic             is_rem;
  logic             neg_a;
  logic             neg_b;
  logic [WIDTH-1:0] mag_a;
  logic [WIDTH-1:0] mag_b;
  ctrl_t            ctrl_d;
  logic             valid_q;
  logic [WIDTH-1:0] num_q;
  logic [WIDTH-1:0] den_q;
  ctrl_t            ctrl_q;

  // Decode the operation
  always_comb begin
    unique case (op_i)
      OP_SDIV: begin
        is_signed = 1'b1;
        is_rem    = 1'b0;
      end
      OP_SREM: begin
        is_signed = 1'b1;
        is_rem    = 1'b1;
      end
      OP_UDIV: begin
        is_signed = 1'b0;
        is_rem    = 1'b0;
      end
      OP_UREM: begin
        is_signed = 1'b0;
        is_rem    = 1'b1;
      end
      default: begin
        is_signed = 1'b0;
        is_rem    = 1'b0;
      end
    endcase
  end

  // Reduce signed operands to magnitudes; negation wraps
  always_comb begin
    neg_a         = is_signed & dividend_i[WIDTH-1];
    neg_b         = is_signed & divisor_i[WIDTH-1];
    mag_a         = neg_a ? ('0 - dividend_i) : dividend_i;
    mag_b         = neg_b ? ('0 - divisor_i) : divisor_i;
    ctrl_d.is_rem = is_rem;
    ctrl_d.neg_q  = neg_a ^ neg_b;
    ctrl_d.neg_r  = neg_a;
    ctrl_d.dz     = (divisor_i == '0);
  end

  // Hold the stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Capture operands on advance
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_q  <= mag_a;
      den_q  <= mag_b;
      ctrl_q <= ctrl_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign ctrl_o  = ctrl_q;

endmodule

/* src/rd64_cell.sv */
module rd64_cell
  import rd64_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] nq_i,
  input  logic [WIDTH-1:0] den_i,
  input  ctrl_t            ctrl_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] nq_o,
  output logic [WIDTH-1:0] den_o,
  output ctrl_t            ctrl_o
);

  // nq carries the unused dividend bits at the top and the quotient bits
  // found so far at the bottom; each cell shifts in one quotient bit.
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic             take;
  logic [WIDTH-1:0] rem_d;
  logic [WIDTH-1:0] nq_d;
  logic             valid_q;
  logic [WIDTH-1:0] rem_q;
  logic [WIDTH-1:0] nq_q;
  logic [WIDTH-1:0] den_q;
  ctrl_t            ctrl_q;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    rem_sh = {rem_i, nq_i[WIDTH-1]};
    diff   = rem_sh - {1'b0, den_i};
    take   = ~diff[WIDTH];
    rem_d  = take ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    nq_d   = {nq_i[WIDTH-2:0], take};
  end

  // Hold the stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Pass the partial result to the next cell
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      den_q  <= den_i;
      ctrl_q <= ctrl_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign den_o   = den_q;
  assign ctrl_o  = ctrl_q;

endmodule

/* src/rd64_out.sv */
`include "restoring_divider_64_assert.svh"

module rd64_out
  import rd64_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] quo_i,
  input  logic [WIDTH-1:0] rem_i,
  input  ctrl_t            ctrl_i,
  output logic             adv_o,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [WIDTH-1:0] result_o,
  output logic             dz_o
);

  logic [WIDTH-1:0] mag;
  logic             neg;
  logic [WIDTH-1:0] res_d;
  logic             take_out;
  logic             pipe_leave;
  logic             out_free;
  logic             out_valid_q;
  logic [WIDTH-1:0] out_res_q;
  logic             out_dz_q;
  logic             skid_valid_q;
  logic [WIDTH-1:0] skid_res_q;
  logic             skid_dz_q;

  // Pick quotient or remainder, apply sign, force zero on zero divisor
  always_comb begin
    mag   = ctrl_i.is_rem ? rem_i : quo_i;
    neg   = ctrl_i.is_rem ? ctrl_i.neg_r : ctrl_i.neg_q;
    res_d = ctrl_i.dz ? '0 : (neg ? ('0 - mag) : mag);
  end

  // The chain moves only while the skid entry is free
  always_comb begin
    take_out   = out_valid_q & ~stall_i;
    out_free   = ~out_valid_q | ~stall_i;
    pipe_leave = valid_i & ~skid_valid_q;
  end

  // Output register and skid entry control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (take_out) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (pipe_leave) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (take_out) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register and skid entry payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take_out) begin
        out_res_q <= skid_res_q;
        out_dz_q  <= skid_dz_q;
      end
    end else if (pipe_leave) begin
      if (out_free) begin
        out_res_q <= res_d;
        out_dz_q  <= ctrl_i.dz;
      end else begin
        skid_res_q <= res_d;
        skid_dz_q  <= ctrl_i.dz;
      end
    end
  end

  assign adv_o    = ~skid_valid_q;
  assign valid_o  = out_valid_q;
  assign result_o = out_res_q;
  assign dz_o     = out_dz_q;

  `RD64_ASSERT_ALWAYS(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid full with empty output")
  `RD64_ASSERT(a_dz_zero, out_valid_q && out_dz_q |-> out_res_q == '0, "nonzero result on zero divisor")
  `RD64_ASSERT(a_skid_fill, $rose(skid_valid_q) |-> $past(out_valid_q && stall_i), "skid filled while output free")

endmodule

/* src/restoring_divider_64.sv */
// Channel   Valid     Stall     Payload
// input     valid_i   stall_o   dividend_bits_i, divisor_bits_i, operation_i
// output    valid_o   stall_i   result_bits_o, divide_by_zero_o
//
// Accepts one transaction per cycle while stall_o is low; each result passes
// through an operand stage, one restoring cell per quotient bit and an output
// register.
// Reset clears only the stage valid bits, the output valid bit and the skid flag.
// A stalled output parks one result in a skid entry; stall_o is that entry's
// full flag and freezes the whole chain until the output register is taken.
`include "restoring_divider_64_assert.svh"

module restoring_divider_64
  import rd64_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [DATA_W-1:0] dividend_bits_i,
  input  logic [DATA_W-1:0] divisor_bits_i,
  input  logic [OP_W-1:0]   operation_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [DATA_W-1:0] result_bits_o,
  output logic              divide_by_zero_o
);

  logic             adv;
  logic             cell_valid [WIDTH+1];
  logic [WIDTH-1:0] cell_rem   [WIDTH+1];
  logic [WIDTH-1:0] cell_nq    [WIDTH+1];
  logic [WIDTH-1:0] cell_den   [WIDTH+1];
  ctrl_t            cell_ctrl  [WIDTH+1];
  logic [WIDTH-1:0] result;

  // Operand stage: magnitudes and sign handling
  rd64_prep #(
    .WIDTH(WIDTH)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (valid_i),
    .dividend_i(dividend_bits_i[WIDTH-1:0]),
    .divisor_i (divisor_bits_i[WIDTH-1:0]),
    .op_i      (op_e'(operation_i)),
    .valid_o   (cell_valid[0]),
    .num_o     (cell_nq[0]),
    .den_o     (cell_den[0]),
    .ctrl_o    (cell_ctrl[0])
  );

  // Partial remainder starts at zero
  assign cell_rem[0] = '0;

  // One restoring cell per quotient bit
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    rd64_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(cell_valid[i]),
      .rem_i  (cell_rem[i]),
      .nq_i   (cell_nq[i]),
      .den_i  (cell_den[i]),
      .ctrl_i (cell_ctrl[i]),
      .valid_o(cell_valid[i+1]),
      .rem_o  (cell_rem[i+1]),
      .nq_o   (cell_nq[i+1]),
      .den_o  (cell_den[i+1]),
      .ctrl_o (cell_ctrl[i+1])
    );
  end

  // Sign fix-up, output register and skid entry
  rd64_out #(
    .WIDTH(WIDTH)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cell_valid[WIDTH]),
    .quo_i   (cell_nq[WIDTH]),
    .rem_i   (cell_rem[WIDTH]),
    .ctrl_i  (cell_ctrl[WIDTH]),
    .adv_o   (adv),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .result_o(result),
    .dz_o    (divide_by_zero_o)
  );

  assign stall_o       = ~adv;
  assign result_bits_o = DATA_W'(result);

  `RD64_ASSERT(a_chain_frozen, stall_o |=> $stable(cell_valid[WIDTH]), "chain moved while skid full")
  `RD64_ASSERT(a_accept_enters, valid_i && !stall_o |=> cell_valid[0], "accepted transaction lost")
  `RD64_ASSERT(a_last_cell_held, cell_valid[WIDTH] && stall_o |=> cell_valid[WIDTH], "stalled result dropped")

endmodule
